FILE: rtl/tpsd_pkg.sv
// ----------------------------------------------------------------------------
// tpsd_pkg
// Shared types, register codes and helpers of the two-pad swipe detector.
// ----------------------------------------------------------------------------
package tpsd_pkg;

  localparam int CntW = 8;
  localparam int TrainW = 9;
  localparam int SampW = 4;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DECAY_SHIFT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ON_OFFSET = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLES_PER_ROUND = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_TRAINING_ROUNDS = 2'd3;

  // configuration reset values
  localparam logic [2:0] RST_DECAY_SHIFT = 3'd4;
  localparam logic [7:0] RST_ON_OFFSET = 8'd100;
  localparam logic [3:0] RST_SAMPLES_PER_ROUND = 4'd5;
  localparam logic [7:0] RST_TRAINING_ROUNDS = 8'd10;

  // gesture state codes
  localparam logic [1:0] GS_IDLE = 2'd0;
  localparam logic [1:0] GS_LEFT = 2'd1;
  localparam logic [1:0] GS_BOTH = 2'd2;

  // training index value once the baseline is settled
  localparam logic [TrainW-1:0] TRAIN_DONE = 9'h100;

  typedef struct packed {
    logic [2:0]      decay_shift;
    logic [CntW-1:0] on_offset;
    logic [SampW-1:0] samples_per_round;
    logic [CntW-1:0] training_rounds;
  } cfg_t;

  typedef struct packed {
    logic       training;
    logic       round_done;
    logic       left_on;
    logic       right_on;
    logic [1:0] gesture_state;
    logic       swipe;
    logic       led;
  } result_t;

  // exponentially weighted baseline update, (2^s - 1) * (base >> s) + (count >> s)
  function automatic logic [CntW-1:0] avg_level(input logic [CntW-1:0] base,
                                                 input logic [CntW-1:0] count,
                                                 input logic [2:0] shamt);
    logic [CntW-1:0] b;
    b = base >> shamt;
    return CntW'((b << shamt) - b + (count >> shamt));
  endfunction

  // pad on when peak reaches the midpoint of baseline and touch level
  function automatic logic pad_on(input logic [CntW-1:0] peak,
                                  input logic [CntW-1:0] idle_lvl,
                                  input logic [CntW-1:0] touch_lvl);
    logic [CntW:0] thr;
    thr = {2'b00, idle_lvl[CntW-1:1]} + {2'b00, touch_lvl[CntW-1:1]};
    return {1'b0, peak} >= thr;
  endfunction

endpackage

FILE: rtl/two_pad_touch_swipe_detector_unit.sv
// ----------------------------------------------------------------------------
// two_pad_touch_swipe_detector_unit
// Left-to-right swipe detector over two capacitive pad discharge counts.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction carries a left and a right pad count (valid/ready)
//   out_* : one result transaction per input transaction, in order
//   cfg_* : register writes (index, data), always ready, one per cycle;
//           write only while no transaction is in flight
// On input acceptance the item is captured in an input register; when it
// advances, the training / round / gesture logic writes the result register
// and the block state, and out_valid rises.
// Throughput is one transaction per cycle while the receiver does not stall;
// the single state update per item in the core sets that rate.
// Reset (rst_n low, synchronous) clears baselines, peaks, counters, gesture
// state and led, restores register defaults and empties both stages.
// When the receiver stalls, the result register holds and the input register
// may still take one more item; in_ready then drops until out_ready returns.
// ----------------------------------------------------------------------------
module two_pad_touch_swipe_detector_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tpsd_pkg::CntW-1:0]     in_left_count,
  input  logic [tpsd_pkg::CntW-1:0]     in_right_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_training,
  output logic                          out_round_done,
  output logic                          out_left_on,
  output logic                          out_right_on,
  output logic [1:0]                    out_gesture_state,
  output logic                          out_swipe,
  output logic                          out_led,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tpsd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tpsd_pkg::CfgDataW-1:0] cfg_data
);
  import tpsd_pkg::*;

  cfg_t            cfg;
  result_t         res;
  result_t         res_r;
  logic            s1_valid_r, s1_valid_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [CntW-1:0] s1_left_r, s1_right_r;
  logic            in_acc, adv;

  // handshake between the two stages
  assign adv = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | adv;
  assign in_acc = in_valid & in_ready;
  assign s1_valid_nxt = in_acc | (s1_valid_r & ~adv);
  assign out_valid_nxt = adv | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_left_r <= in_left_count;
      s1_right_r <= in_right_count;
    end
  end

  tpsd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpsd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .go          (adv),
    .left_count  (s1_left_r),
    .right_count (s1_right_r),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_training = res_r.training;
  assign out_round_done = res_r.round_done;
  assign out_left_on = res_r.left_on;
  assign out_right_on = res_r.right_on;
  assign out_gesture_state = res_r.gesture_state;
  assign out_swipe = res_r.swipe;
  assign out_led = res_r.led;

endmodule

FILE: rtl/tpsd_cfg.sv
// ----------------------------------------------------------------------------
// tpsd_cfg
// Configuration register file written through the cfg transaction channel.
// ----------------------------------------------------------------------------
module tpsd_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tpsd_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [tpsd_pkg::CfgDataW-1:0]   cfg_data,
  output tpsd_pkg::cfg_t                  cfg
);
  import tpsd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr;

  // writes are always accepted and land in the register at the accepting edge
  assign cfg_ready = 1'b1;
  assign wr = cfg_valid & cfg_ready;

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (cfg_index)
        CFG_DECAY_SHIFT:       cfg_nxt.decay_shift = cfg_data[2:0];
        CFG_ON_OFFSET:         cfg_nxt.on_offset = cfg_data;
        CFG_SAMPLES_PER_ROUND: cfg_nxt.samples_per_round = cfg_data[3:0];
        CFG_TRAINING_ROUNDS:   cfg_nxt.training_rounds = cfg_data;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decay_shift <= RST_DECAY_SHIFT;
      cfg_r.on_offset <= RST_ON_OFFSET;
      cfg_r.samples_per_round <= RST_SAMPLES_PER_ROUND;
      cfg_r.training_rounds <= RST_TRAINING_ROUNDS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/tpsd_core.sv
// ----------------------------------------------------------------------------
// tpsd_core
// Baseline training, per-round peak tracking, pad classification and the
// swipe state machine; state advances once per transaction.
// ----------------------------------------------------------------------------
module tpsd_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tpsd_pkg::cfg_t             cfg,
  input  logic                       go,
  input  logic [tpsd_pkg::CntW-1:0]  left_count,
  input  logic [tpsd_pkg::CntW-1:0]  right_count,
  output tpsd_pkg::result_t          res
);
  import tpsd_pkg::*;

  logic [CntW-1:0]   idle_l_r, idle_r_r, idle_l_nxt, idle_r_nxt;
  logic [CntW-1:0]   touch_l_r, touch_r_r, touch_l_nxt, touch_r_nxt;
  logic [TrainW-1:0] train_r, train_nxt;
  logic [SampW-1:0]  samp_r, samp_nxt, samp_inc;
  logic [CntW-1:0]   lpeak_r, rpeak_r, lpeak_nxt, rpeak_nxt;
  logic [1:0]        gest_r, gest_nxt, gest_cur;
  logic              led_r, led_nxt;
  logic              lon, ron;

  // next state and result for the item in flight
  always_comb begin
    idle_l_nxt = idle_l_r;
    idle_r_nxt = idle_r_r;
    touch_l_nxt = touch_l_r;
    touch_r_nxt = touch_r_r;
    train_nxt = train_r;
    samp_nxt = samp_r;
    lpeak_nxt = lpeak_r;
    rpeak_nxt = rpeak_r;
    led_nxt = led_r;
    samp_inc = samp_r + 1'b1;
    lon = 1'b0;
    ron = 1'b0;
    res = '0;

    // an unused code falls back to idle
    case (gest_r)
      GS_LEFT: gest_cur = GS_LEFT;
      GS_BOTH: gest_cur = GS_BOTH;
      default: gest_cur = GS_IDLE;
    endcase
    gest_nxt = gest_cur;

    if (!train_r[TrainW-1]) begin
      // baseline training
      res.training = 1'b1;
      if (train_r == '0) begin
        idle_l_nxt = left_count;
        idle_r_nxt = right_count;
      end else begin
        idle_l_nxt = avg_level(idle_l_r, left_count, cfg.decay_shift);
        idle_r_nxt = avg_level(idle_r_r, right_count, cfg.decay_shift);
      end
      if (train_r >= {1'b0, cfg.training_rounds}) begin
        touch_l_nxt = idle_l_nxt + cfg.on_offset;
        touch_r_nxt = idle_r_nxt + cfg.on_offset;
        train_nxt = TRAIN_DONE;
      end else begin
        train_nxt = train_r + 1'b1;
      end
    end else begin
      // peak tracking over the round
      lpeak_nxt = (left_count > lpeak_r) ? left_count : lpeak_r;
      rpeak_nxt = (right_count > rpeak_r) ? right_count : rpeak_r;
      samp_nxt = samp_inc;
      if (samp_inc >= cfg.samples_per_round) begin
        res.round_done = 1'b1;
        lon = pad_on(lpeak_nxt, idle_l_r, touch_l_r);
        ron = pad_on(rpeak_nxt, idle_r_r, touch_r_r);
        // gesture machine, both then right only is a swipe
        if (gest_cur == GS_BOTH && ron && !lon) begin
          res.swipe = 1'b1;
          led_nxt = ~led_r;
          gest_nxt = GS_IDLE;
        end else if (lon && ron) begin
          gest_nxt = GS_BOTH;
        end else if (lon) begin
          gest_nxt = GS_LEFT;
        end else begin
          gest_nxt = GS_IDLE;
        end
        lpeak_nxt = '0;
        rpeak_nxt = '0;
        samp_nxt = '0;
      end
    end

    res.left_on = lon;
    res.right_on = ron;
    res.gesture_state = gest_nxt;
    res.led = led_nxt;
  end

  // state update on each advancing transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_l_r <= '0;
      idle_r_r <= '0;
      touch_l_r <= '0;
      touch_r_r <= '0;
      train_r <= '0;
      samp_r <= '0;
      lpeak_r <= '0;
      rpeak_r <= '0;
      gest_r <= GS_IDLE;
      led_r <= 1'b0;
    end else if (go) begin
      idle_l_r <= idle_l_nxt;
      idle_r_r <= idle_r_nxt;
      touch_l_r <= touch_l_nxt;
      touch_r_r <= touch_r_nxt;
      train_r <= train_nxt;
      samp_r <= samp_nxt;
      lpeak_r <= lpeak_nxt;
      rpeak_r <= rpeak_nxt;
      gest_r <= gest_nxt;
      led_r <= led_nxt;
    end
  end

endmodule

FILE: rtl/tpsd_checker.sv
// ----------------------------------------------------------------------------
// tpsd_checker
// Port-level checks of the swipe detector, bound to the top level.
// ----------------------------------------------------------------------------
module tpsd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_training,
  input logic                          out_round_done,
  input logic                          out_left_on,
  input logic                          out_right_on,
  input logic [1:0]                    out_gesture_state,
  input logic                          out_swipe,
  input logic                          out_led
);
  import tpsd_pkg::*;

  // stalled result holds valid, led, gesture state, swipe and round_done
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led) &&
      $stable(out_gesture_state) && $stable(out_swipe) && $stable(out_round_done))
    else $error("result changed while stalled");

  // training items never classify
  a_train_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_training |-> !out_round_done && !out_swipe &&
      !out_left_on && !out_right_on)
    else $error("training item carries classification");

  // a swipe ends a round with right only and returns to idle
  a_swipe_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_swipe |-> out_round_done && out_right_on && !out_left_on &&
      out_gesture_state == GS_IDLE)
    else $error("malformed swipe result");

  // gesture state follows the pad flags at round end
  a_gesture_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_round_done && !out_swipe |->
      out_gesture_state == {out_left_on & out_right_on, out_left_on & ~out_right_on})
    else $error("gesture state mismatch at round end");

endmodule

bind two_pad_touch_swipe_detector_unit tpsd_checker u_tpsd_checker (.*);
